/* src/ordered_key_list_append_remove_unit_macros.svh */
// Assertion macros shared by the ordered key list RTL.
`ifndef ORDERED_KEY_LIST_APPEND_REMOVE_UNIT_MACROS_SVH
`define ORDERED_KEY_LIST_APPEND_REMOVE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OKL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OKL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/okl_pkg.sv */
// Shared types and constants for the ordered key list.
package okl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  // input mode
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // operation broadcast to every cell
  typedef struct packed {
    logic             append;
    logic             remove;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  // contents one cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } cell_link_t;

endpackage

/* src/ordered_key_list_append_remove_unit.sv */
// Top level of the ordered key list: cell chain, count and result register.
// Ordered key list with append and remove-by-key.
// Input channel (in_*): one beat per operation. in_tuser carries the mode
// (0 append at tail, 1 remove oldest entry with an equal key), in_tdata the
// signed 32-bit key.
// Result channel (out_*): exactly one beat per input beat, in order, with a
// 3-bit status (appended, removed, not found, empty, full) and the entry
// count after the step.
// The result is registered: a beat accepted at an edge shows on out_* after that edge.
// Throughput is one beat per cycle; the whole operation is done in a single
// pass through the chain of CAPACITY cells, where every cell compares its key
// in parallel and the first-match chain picks which cells shift toward head.
// A stall on out_tready holds the result register and drops in_tready; new
// input is taken in the same cycle the waiting result is taken.
// Reset (rst_n low, synchronous) empties the list and drops out_tvalid.
`include "ordered_key_list_append_remove_unit_macros.svh"
module ordered_key_list_append_remove_unit #(
  parameter int CAPACITY = okl_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [okl_pkg::IN_TDATA_W-1:0] in_tdata,  // [31:0] key
  input  logic [0:0]                     in_tuser,  // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [okl_pkg::OUT_TDATA_W-1:0] out_tdata // [2:0] status, [7:3] count
);
  import okl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                    in_acc;
  cell_ctrl_t              ctrl;
  cell_link_t              links [CAPACITY];
  logic [CAPACITY:0]       hit_chain;
  logic [CAPACITY-1:0]     vld_vec;
  logic                    full;
  logic                    empty;
  logic                    found;

  logic [CW-1:0]           count_r, count_nxt;
  logic [STATUS_W-1:0]     status;
  logic [CW+COUNT_W-1:0]   count_pad;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  // handshake: take a beat whenever the result register is free or draining
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign ctrl.append = in_acc && (in_tuser[0] == MODE_APPEND);
  assign ctrl.remove = in_acc && (in_tuser[0] == MODE_REMOVE);
  assign ctrl.key    = in_tdata[KEY_W-1:0];

  assign hit_chain[0] = 1'b0;

  // chain of cells, slot 0 holds the oldest key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       prev_valid;
    cell_link_t from_next;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = links[i-1].valid;
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign from_next = '0;
    end else begin : g_mid
      assign from_next = links[i+1];
    end

    okl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_valid(prev_valid),
      .from_next (from_next),
      .hit_in    (hit_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .link      (links[i])
    );

    assign vld_vec[i] = links[i].valid;
  end

  assign full  = vld_vec[CAPACITY-1];
  assign empty = !vld_vec[0];
  assign found = hit_chain[CAPACITY];

  // status and next count
  always_comb begin
    count_nxt = count_r;
    if (in_tuser[0] == MODE_APPEND) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        status    = ST_APPENDED;
        count_nxt = count_r + CW'(1);
      end
    end else if (empty) begin
      status = ST_EMPTY;
    end else if (found) begin
      status    = ST_REMOVED;
      count_nxt = count_r - CW'(1);
    end else begin
      status = ST_NOT_FOUND;
    end
  end

  // count field carries the low bits of the entry count
  assign count_pad = {{COUNT_W{1'b0}}, count_nxt};

  // result register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (in_acc) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {count_pad[COUNT_W-1:0], status};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r <= count_nxt;
      end
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // occupied slots are always a contiguous run from the head
  `OKL_ASSERT_IMP(a_vld_contig, 1'b1, ((vld_vec >> 1) & ~vld_vec) == '0, "valid bits have a hole")
  // count tracks the occupied slots
  `OKL_ASSERT_IMP(a_count_match, 1'b1, $countones(vld_vec) == count_r, "count mismatch")
  // a successful append grows the list by one
  `OKL_ASSERT_NXT(a_append_grow, ctrl.append && !full, count_r == $past(count_r) + CW'(1), "append lost")
  // every accepted beat leaves a result waiting
  `OKL_ASSERT_NXT(a_result_out, in_acc, out_tvalid_r, "result missing after accept")

endmodule

/* src/okl_cell.sv */
// One list slot: holds a key, takes an appended key at the tail, shifts on remove.
module okl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  okl_pkg::cell_ctrl_t ctrl,
  input  logic               prev_valid, // slot toward the head is occupied
  input  okl_pkg::cell_link_t from_next, // slot toward the tail
  input  logic               hit_in,     // a match exists nearer the head
  output logic               hit_out,
  output okl_pkg::cell_link_t link
);
  import okl_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             match;
  logic             tail;
  logic             shift;

  // compare and first-match chain
  assign match   = valid_r && (key_r == ctrl.key);
  assign hit_out = hit_in || match;
  assign shift   = ctrl.remove && hit_out;
  assign tail    = ctrl.append && !valid_r && prev_valid;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (tail) begin
      key_nxt   = ctrl.key;
      valid_nxt = 1'b1;
    end else if (shift) begin
      key_nxt   = from_next.key;
      valid_nxt = from_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // key store needs no reset; read only while valid
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link.valid = valid_r;
  assign link.key   = key_r;

endmodule
